### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deque block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/dqdel_pkg.sv
// ----------------------------------------------------------------------------
// dqdel_pkg
// Types, codes and defaults shared by the deque controller and datapath.
// ----------------------------------------------------------------------------
package dqdel_pkg;

	localparam int CAPACITY_DEF = 16;

	// command codes; codes 6 and 7 are no-ops
	typedef enum logic [2:0] {
		CMD_INS_HEAD  = 3'd0,
		CMD_INS_TAIL  = 3'd1,
		CMD_DEL_HEAD  = 3'd2,
		CMD_DEL_TAIL  = 3'd3,
		CMD_DEL_VALUE = 3'd4,
		CMD_READ_ALL  = 3'd5
	} cmd_code_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] entry_value;
		logic [4:0]         count_after;
		logic               last_result;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic read;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic last_step;
	} dp_sts_t;

endpackage

### rtl/dqdel_ctrl.sv
// ----------------------------------------------------------------------------
// dqdel_ctrl
// Command sequencer: routes each item to a one-cycle update, a value scan
// or a readout pass, and holds busy until the item is finished.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqdel_ctrl
	import dqdel_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] command,
	input  dp_sts_t    sts,
	output dp_ctl_t    ctl,
	output logic       busy
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_DEL_VALUE && !sts.cnt_zero) begin
						state_d = ST_SCAN;
					end else if (command == CMD_READ_ALL && !sts.cnt_zero) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			ST_SCAN, ST_READ: begin
				if (sts.last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_EXEC: ctl.exec = 1'b1;
			ST_SCAN: ctl.scan = 1'b1;
			ST_READ: ctl.read = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	`AST_NEXT(a_exec_one_cycle, clk, arst_n, state_q == ST_EXEC, state_q == ST_IDLE)
	`AST_NEXT(a_pass_ends, clk, arst_n, (state_q == ST_SCAN || state_q == ST_READ) && sts.last_step, state_q == ST_IDLE)

endmodule

### rtl/dqdel_dpath.sv
// ----------------------------------------------------------------------------
// dqdel_dpath
// Entry shift line, fill count, pass counter and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqdel_dpath
	import dqdel_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    request,
	input  dp_ctl_t ctl,
	output dp_sts_t sts,
	output logic    done,
	output rsp_t    response
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] entry_q [CAPACITY];
	logic [2:0]         cmd_q;
	logic signed [31:0] opnd_q;
	logic [CW-1:0]      cnt_q, cnt_d, cnt_m1;
	logic [CW-1:0]      steps_q;
	logic               found_q;
	logic               done_q;
	rsp_t               rsp_q, rsp_d;
	logic               emit;

	logic full, empty, last_step, match;
	logic ins_head, ins_tail, del_head, del_tail, drop_scan, drop, rotate;

	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign last_step = (steps_q == CW'(1));
	assign cnt_m1    = cnt_q - CW'(1);
	assign match     = (entry_q[0] == opnd_q);

	// decode the update for this cycle
	always_comb begin
		ins_head = 1'b0;
		ins_tail = 1'b0;
		del_head = 1'b0;
		del_tail = 1'b0;
		if (ctl.exec) begin
			unique case (cmd_q)
				CMD_INS_HEAD: ins_head = !full;
				CMD_INS_TAIL: ins_tail = !full;
				CMD_DEL_HEAD: del_head = !empty;
				CMD_DEL_TAIL: del_tail = !empty;
				default: ;
			endcase
		end
	end

	// scan drops the first match, every other head goes to the tail
	assign drop_scan = ctl.scan && !found_q && match;
	assign drop      = del_head || drop_scan;
	assign rotate    = (ctl.scan && !drop_scan) || ctl.read;

	always_comb begin
		cnt_d = cnt_q;
		if (ins_head || ins_tail) begin
			cnt_d = cnt_q + CW'(1);
		end else if (del_head || del_tail || drop_scan) begin
			cnt_d = cnt_m1;
		end
	end

	// entry shift line
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
		always_ff @(posedge clk) begin
			if (ins_head) begin
				entry_q[i] <= (i == 0) ? opnd_q : entry_q[PREV];
			end else if (ins_tail && cnt_q == CW'(i)) begin
				entry_q[i] <= opnd_q;
			end else if (drop) begin
				entry_q[i] <= entry_q[NEXT];
			end else if (rotate) begin
				entry_q[i] <= (cnt_m1 == CW'(i)) ? entry_q[0] : entry_q[NEXT];
			end
		end
	end

	// hold the item operands
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= request.command;
			opnd_q <= request.operand_value;
		end
	end

	// fill count, pass counter and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			steps_q <= '0;
			found_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (ctl.load) begin
				steps_q <= cnt_q;
				found_q <= 1'b0;
			end else if (ctl.scan || ctl.read) begin
				steps_q <= steps_q - CW'(1);
				found_q <= found_q || drop_scan;
			end
		end
	end

	// build the result
	always_comb begin
		rsp_d             = '0;
		rsp_d.count_after = 5'(cnt_d);
		rsp_d.last_result = 1'b1;
		rsp_d.status      = STAT_OK;
		emit              = 1'b0;
		if (ctl.exec) begin
			emit = 1'b1;
			unique case (cmd_q) inside
				CMD_INS_HEAD, CMD_INS_TAIL: rsp_d.status = full ? STAT_FULL : STAT_OK;
				CMD_DEL_HEAD, CMD_DEL_TAIL: rsp_d.status = empty ? STAT_EMPTY : STAT_OK;
				CMD_DEL_VALUE:              rsp_d.status = STAT_NOT_FOUND;
				CMD_READ_ALL:               rsp_d.status = STAT_EMPTY;
				default:                    rsp_d.status = STAT_OK;
			endcase
		end else if (ctl.scan) begin
			emit         = last_step;
			rsp_d.status = (found_q || drop_scan) ? STAT_OK : STAT_NOT_FOUND;
		end else if (ctl.read) begin
			emit              = 1'b1;
			rsp_d.entry_value = entry_q[0];
			rsp_d.last_result = last_step;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign done          = done_q;
	assign response      = rsp_q;
	assign sts.cnt_zero  = empty;
	assign sts.last_step = last_step;

	`AST_NEXT(a_readout_burst, clk, arst_n, done_q && !rsp_q.last_result, done_q)
	`AST_IMPLY(a_full_at_cap, clk, arst_n, done_q && rsp_q.status == STAT_FULL, cnt_q == CW'(CAPACITY))
	`AST_IMPLY(a_empty_at_zero, clk, arst_n, done_q && rsp_q.status == STAT_EMPTY, cnt_q == '0)

endmodule

### rtl/deque_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// Bounded ordered list of signed 32-bit entries with head/tail insert and
// delete, delete of the first matching value, and full readout.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Inserts, head/tail
// deletes, no-op codes and commands on an empty list pass through an accept
// step, then an update step; delete-by-value and read-all accept, then take
// one pass step per entry held, since the entry shift line moves one entry
// past the head per cycle. Each result shows on response for one cycle with
// done high, in the cycle after its update; the receiver cannot stall, so
// it must take every done. A read-all delivers one result per entry held on
// consecutive cycles, the last one with last_result set. The entry line is
// not cleared at reset; the fill count, pass counter, match flag and done are.
module deque_with_delete_by_value
	import dqdel_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t response
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	dqdel_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	dqdel_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.ctl      (ctl),
		.sts      (sts),
		.done     (done),
		.response (response)
	);

endmodule
